>>> src/multidrop_frame_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// Multidrop frame receiver assertion macros
// Short forms for the clocked checks used in the receiver top level.
// ----------------------------------------------------------------------------
`ifndef MULTIDROP_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define MULTIDROP_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mfr_pkg.sv
// ----------------------------------------------------------------------------
// Multidrop frame receiver package
// Phase codes, reply codes, delimiter set and the item types shared by the
// front end, the result queue and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfr_pkg;

  // Receive phase
  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_DATA = 2'd1,
    PH_CSUM = 2'd2
  } phase_e;

  // Reply bytes and checksum mask
  localparam logic [7:0] ACK_GOOD = 8'h80;
  localparam logic [7:0] ACK_BAD  = 8'h81;
  localparam logic [7:0] SUM_MASK = 8'h7f;

  // Frame delimiters
  localparam logic [7:0] DELIM_LF    = 8'h0a;
  localparam logic [7:0] DELIM_CR    = 8'h0d;
  localparam logic [7:0] DELIM_SEMI  = 8'h3b;
  localparam logic [7:0] DELIM_QUERY = 8'h3f;
  localparam logic [7:0] DELIM_DOLL  = 8'h24;
  localparam logic [7:0] DELIM_BANG  = 8'h21;

  // Result queue between front end and output
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Front end metadata held while the ring read completes
  typedef struct packed {
    logic       ack_valid;
    logic [7:0] ack_byte;
    logic       use_ram;
    phase_e     phase;
  } front_meta_t;

  // One finished result
  typedef struct packed {
    logic       ack_valid;
    logic [7:0] ack_byte;
    logic [7:0] read_data;
    phase_e     phase;
  } out_item_t;

  function automatic logic is_delim(input logic [7:0] b);
    is_delim = (b == DELIM_LF) || (b == DELIM_CR) || (b == DELIM_SEMI) ||
               (b == DELIM_QUERY) || (b == DELIM_DOLL) || (b == DELIM_BANG);
  endfunction

endpackage

>>> src/mfr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mfr_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small FIFO of finished results; the head entry drives the output ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  mfr_pkg::out_item_t            item_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output mfr_pkg::out_item_t            head_o,
  output logic [mfr_pkg::QCNT_W-1:0]    count_o
);

  mfr_pkg::out_item_t               slot_q [mfr_pkg::QDEPTH];
  logic [mfr_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [mfr_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [mfr_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

>>> src/mfr_front.sv
// ----------------------------------------------------------------------------
// Receiver front end
// Classifies each input transfer, updates phase, checksum and ring pointers,
// drives the ring RAM, and hands a finished result to the queue in the next
// cycle, once the registered ring read has returned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_front #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     station_addr_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           address_bit_i,
  // ring RAM
  output logic                           ram_we_o,
  output logic [$clog2(FIFO_DEPTH)-1:0]  ram_waddr_o,
  output logic [7:0]                     ram_wdata_o,
  output logic [$clog2(FIFO_DEPTH)-1:0]  ram_raddr_o,
  input  logic [7:0]                     ram_rdata_i,
  // result queue
  input  logic [mfr_pkg::QCNT_W-1:0]     q_count_i,
  output logic                           push_o,
  output mfr_pkg::out_item_t             item_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);

  mfr_pkg::phase_e       phase_q, phase_d;
  logic [7:0]            sum_q, sum_d;
  logic [PTR_W-1:0]      wp_q, wp_d, wp_next;
  logic [PTR_W-1:0]      rp_q, rp_d, rp_next;
  logic                  slot0_wr_q, slot0_wr_d;
  logic                  s1_valid_q;
  mfr_pkg::front_meta_t  s1_meta_q, meta_d;
  logic [mfr_pkg::QCNT_W:0] occupancy;
  logic                  accept;

  // Room check: queued results plus the one in the read stage
  assign occupancy  = {1'b0, q_count_i} + {{mfr_pkg::QCNT_W{1'b0}}, s1_valid_q};
  assign in_ready_o = (occupancy < (mfr_pkg::QCNT_W + 1)'(mfr_pkg::QDEPTH));
  assign accept     = in_valid_i && in_ready_o;

  // Ring pointer advance with wrap
  assign wp_next = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == LAST_SLOT) ? '0 : rp_q + 1'b1;

  // Classify and update state
  always_comb begin
    phase_d    = phase_q;
    sum_d      = sum_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    slot0_wr_d = slot0_wr_q;
    ram_we_o   = 1'b0;
    meta_d     = '{ack_valid: 1'b0, ack_byte: 8'h00, use_ram: 1'b0,
                   phase: phase_q};
    if (accept) begin
      if (func_i) begin
        // queue read
        if (wp_q != rp_q) begin
          rp_d           = rp_next;
          meta_d.use_ram = (rp_next != '0) || slot0_wr_q;
        end
      end else begin
        case (phase_q)
          mfr_pkg::PH_CSUM: begin
            meta_d.ack_valid = 1'b1;
            meta_d.ack_byte  = (rx_byte_i == (sum_q & mfr_pkg::SUM_MASK)) ?
                               mfr_pkg::ACK_GOOD : mfr_pkg::ACK_BAD;
            phase_d          = mfr_pkg::PH_ADDR;
          end
          mfr_pkg::PH_DATA: begin
            sum_d    = sum_q + rx_byte_i;
            wp_d     = wp_next;
            ram_we_o = 1'b1;
            if (wp_next == '0) begin
              slot0_wr_d = 1'b1;
            end
            if (mfr_pkg::is_delim(rx_byte_i)) begin
              phase_d = mfr_pkg::PH_CSUM;
            end
          end
          mfr_pkg::PH_ADDR: begin
            if (address_bit_i && (rx_byte_i == station_addr_i)) begin
              phase_d = mfr_pkg::PH_DATA;
              sum_d   = 8'h00;
            end
          end
          default: begin
            // unused phase code: bytes are dropped
          end
        endcase
      end
      meta_d.phase = phase_d;
    end
  end

  assign ram_waddr_o = wp_next;
  assign ram_wdata_o = rx_byte_i;
  assign ram_raddr_o = rp_next;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mfr_pkg::PH_ADDR;
      sum_q      <= 8'h00;
      wp_q       <= '0;
      rp_q       <= LAST_SLOT;
      slot0_wr_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      sum_q      <= sum_d;
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      slot0_wr_q <= slot0_wr_d;
      s1_valid_q <= accept;
    end
  end

  // Read stage metadata
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta_d;
    end
  end

  // Merge ring data; slot zero reads as zero until first written
  assign push_o           = s1_valid_q;
  assign item_o.ack_valid = s1_meta_q.ack_valid;
  assign item_o.ack_byte  = s1_meta_q.ack_byte;
  assign item_o.read_data = s1_meta_q.use_ram ? ram_rdata_i : 8'h00;
  assign item_o.phase     = s1_meta_q.phase;

endmodule

>>> src/multidrop_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Multidrop frame receiver
// Receive side of a 9-bit multidrop serial link: address match, data ring
// with running checksum, checksum reply, and queue reads.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i/in_ready_o   func_i, rx_byte_i, address_bit_i
//   output    out        out_valid_o/out_ready_i ack_valid_o, ack_byte_o,
//                                                read_data_o, receive_phase_o
//   config    in         cfg_we_i                cfg_wdata_i (station address)
//
// One transfer per cycle sustained while input ready is high. A result passes
// the read stage (the registered ring read) and is then written to the result
// queue, whose head entry drives the output channel.
// A four-entry result queue absorbs output stalls; input ready drops while the
// queue and the read stage together hold four results.
// Reset is asynchronous and needs no clearing pass: slot zero of the ring
// is tracked by a single written flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multidrop_frame_receiver_unit_assert.svh"

module multidrop_frame_receiver_unit #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  input  logic       address_bit_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       ack_valid_o,
  output logic [7:0] ack_byte_o,
  output logic [7:0] read_data_o,
  output logic [1:0] receive_phase_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  logic [7:0]                    station_addr_q;
  logic                          ram_we;
  logic [PTR_W-1:0]              ram_waddr;
  logic [7:0]                    ram_wdata;
  logic [PTR_W-1:0]              ram_raddr;
  logic [7:0]                    ram_rdata;
  logic                          push;
  mfr_pkg::out_item_t            push_item;
  mfr_pkg::out_item_t            head;
  logic [mfr_pkg::QCNT_W-1:0]    q_count;

  // Station address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_addr_q <= 8'h00;
    end else if (cfg_we_i) begin
      station_addr_q <= cfg_wdata_i;
    end
  end

  // Front end
  mfr_front #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .station_addr_i (station_addr_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .rx_byte_i      (rx_byte_i),
    .address_bit_i  (address_bit_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .q_count_i      (q_count),
    .push_o         (push),
    .item_o         (push_item)
  );

  // Data ring
  mfr_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result queue
  mfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .head_o  (head),
    .count_o (q_count)
  );

  assign ack_valid_o     = head.ack_valid;
  assign ack_byte_o      = head.ack_byte;
  assign read_data_o     = head.read_data;
  assign receive_phase_o = head.phase;

  // Checks
  `MFR_ASSERT_NOW(a_no_q_overflow, clk_i, rst_ni, push,
    (q_count < mfr_pkg::QCNT_W'(mfr_pkg::QDEPTH)), "result queue overflow")
  `MFR_ASSERT_NEXT(a_accept_pushes, clk_i, rst_ni, (in_valid_i && in_ready_o), push,
    "accepted transfer did not reach the queue")
  `MFR_ASSERT_NOW(a_ack_ends_frame, clk_i, rst_ni, (out_valid_o && ack_valid_o),
    (receive_phase_o == mfr_pkg::PH_ADDR), "reply without return to address phase")
  `MFR_ASSERT_NOW(a_read_no_ack, clk_i, rst_ni, (out_valid_o && (read_data_o != 8'h00)),
    !ack_valid_o, "queue data and reply in one result")

endmodule

>>> tb/sv/tb_multidrop_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multidrop frame receiver testbench
// Sends address, data, delimiter, checksum and queue-read transfers into the
// receiver and checks every result transfer, field by field, against a
// transfer-level predictor of the frame state, the running sum and the ring.
// Random idle bursts on the input side and random stalls on the output side
// are used, and the station address is rewritten between phases.
// ---------------------------------------------------------------------------
module tb_multidrop_frame_receiver_unit;

  localparam int unsigned RING_DEPTH  = 64;
  localparam int unsigned PTR_W       = $clog2(RING_DEPTH);
  localparam int unsigned WORK_TARGET = 550;
  localparam int unsigned QUIET_TAIL  = 80;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_SHOWN   = 10;

  // Input function codes
  localparam logic FN_RX   = 1'b0;
  localparam logic FN_READ = 1'b1;

  // One predicted result
  typedef struct {
    logic            ack_valid;
    logic [7:0]      ack_byte;
    logic [7:0]      read_data;
    mfr_pkg::phase_e phase;
  } reply_t;

  // DUT connections
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [7:0] cfg_wdata_i   = 8'h00;
  logic       in_valid_i    = 1'b0;
  logic       func_i        = 1'b0;
  logic [7:0] rx_byte_i     = 8'h00;
  logic       address_bit_i = 1'b0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       ack_valid_o;
  logic [7:0] ack_byte_o;
  logic [7:0] read_data_o;
  logic [1:0] receive_phase_o;

  // Shadow receiver state
  logic [7:0]       station_addr;
  mfr_pkg::phase_e  rx_phase;
  logic [7:0]       frame_sum;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [7:0]       ring_mem [RING_DEPTH];
  reply_t           reply_q [$];

  // Run bookkeeping
  bit          idle_en       = 1'b1;
  int unsigned work_cnt      = 0;
  int unsigned sent_cnt      = 0;
  int unsigned checked_cnt   = 0;
  int unsigned err_cnt       = 0;
  int unsigned frames_opened = 0;
  int unsigned acks_good     = 0;
  int unsigned acks_bad      = 0;
  int unsigned read_hits     = 0;
  int unsigned empty_reads   = 0;
  int unsigned ring_overruns = 0;
  int unsigned cfg_writes    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned hold_cycles   = 0;
  reply_t      got_exp;

  multidrop_frame_receiver_unit #(
    .FIFO_DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .rx_byte_i      (rx_byte_i),
    .address_bit_i  (address_bit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ack_valid_o    (ack_valid_o),
    .ack_byte_o     (ack_byte_o),
    .read_data_o    (read_data_o),
    .receive_phase_o(receive_phase_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Random single bit and random byte
  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Frame delimiter set
  function automatic logic ends_frame(input logic [7:0] b);
    return (b == mfr_pkg::DELIM_LF) || (b == mfr_pkg::DELIM_CR) ||
           (b == mfr_pkg::DELIM_SEMI) || (b == mfr_pkg::DELIM_QUERY) ||
           (b == mfr_pkg::DELIM_DOLL) || (b == mfr_pkg::DELIM_BANG);
  endfunction

  function automatic logic [7:0] delim_byte(input int unsigned k);
    case (k)
      0:       return mfr_pkg::DELIM_LF;
      1:       return mfr_pkg::DELIM_CR;
      2:       return mfr_pkg::DELIM_SEMI;
      3:       return mfr_pkg::DELIM_QUERY;
      4:       return mfr_pkg::DELIM_DOLL;
      default: return mfr_pkg::DELIM_BANG;
    endcase
  endfunction

  // Random byte that does not close a frame
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = rand_byte(); while (ends_frame(b));
    return b;
  endfunction

  // Advance the shadow receiver by one accepted transfer and queue its reply;
  // returns 0 when the receiver ignores the byte
  function automatic bit predict_reply(input logic f, input logic [7:0] b,
                                       input logic a);
    reply_t r;
    bit     worked;
    r.ack_valid = 1'b0;
    r.ack_byte  = 8'h00;
    r.read_data = 8'h00;
    worked      = 1'b1;
    if (f == FN_READ) begin
      if (wr_ptr != rd_ptr) begin
        rd_ptr      = rd_ptr + 1'b1;
        r.read_data = ring_mem[rd_ptr];
        read_hits++;
      end else begin
        empty_reads++;
      end
    end else if (rx_phase == mfr_pkg::PH_CSUM) begin
      r.ack_valid = 1'b1;
      if (b == (frame_sum & mfr_pkg::SUM_MASK)) begin
        r.ack_byte = mfr_pkg::ACK_GOOD;
        acks_good++;
      end else begin
        r.ack_byte = mfr_pkg::ACK_BAD;
        acks_bad++;
      end
      rx_phase = mfr_pkg::PH_ADDR;
    end else if (rx_phase == mfr_pkg::PH_DATA) begin
      frame_sum        = frame_sum + b;
      wr_ptr           = wr_ptr + 1'b1;
      ring_mem[wr_ptr] = b;
      // writer caught the reader: unread bytes are lost
      if (wr_ptr == rd_ptr) ring_overruns++;
      if (ends_frame(b)) rx_phase = mfr_pkg::PH_CSUM;
    end else if (a && b == station_addr) begin
      rx_phase  = mfr_pkg::PH_DATA;
      frame_sum = 8'h00;
      frames_opened++;
    end else begin
      worked = 1'b0;
    end
    r.phase = rx_phase;
    reply_q.push_back(r);
    return worked;
  endfunction

  // Present one input transfer, hold it until accepted, then predict it.
  // Valid stays high afterwards so back-to-back transfers need no drop.
  task automatic send_item(input logic f, input logic [7:0] b, input logic a);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    rx_byte_i     <= b;
    address_bit_i <= a;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    if (predict_reply(f, b, a)) work_cnt++;
  endtask

  // Station address write, only once the receiver has drained
  task automatic set_station(input logic [7:0] v);
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    station_addr  = v;
    cfg_writes++;
  endtask

  // Well-formed frame: address, len data bytes, delimiter, checksum
  task automatic send_frame(input int unsigned len, input bit sum_ok);
    logic [7:0] csum;
    logic [7:0] tweak;
    // close whatever frame noise left open
    if (rx_phase == mfr_pkg::PH_DATA)
      send_item(FN_RX, delim_byte($urandom_range(0, 5)), rand_bit());
    if (rx_phase == mfr_pkg::PH_CSUM)
      send_item(FN_RX, rand_byte(), rand_bit());
    // stray address for another station
    if ($urandom_range(0, 3) == 0) begin
      tweak = 8'($urandom_range(1, 255));
      send_item(FN_RX, station_addr ^ tweak, 1'b1);
    end
    send_item(FN_RX, station_addr, 1'b1);
    repeat (len) begin
      if ($urandom_range(0, 4) == 0)
        send_item(FN_READ, rand_byte(), rand_bit());
      send_item(FN_RX, plain_byte(), rand_bit());
    end
    send_item(FN_RX, delim_byte($urandom_range(0, 5)), rand_bit());
    csum = frame_sum & mfr_pkg::SUM_MASK;
    if (!sum_ok) begin
      tweak = 8'($urandom_range(1, 255));
      csum  = csum ^ tweak;
    end
    send_item(FN_RX, csum, rand_bit());
  endtask

  // Arbitrary transfers, biased toward the station address
  task automatic send_noise(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) b = station_addr;
      else b = rand_byte();
      send_item(($urandom_range(0, 3) == 0) ? FN_READ : FN_RX, b, rand_bit());
    end
  endtask

  task automatic send_reads(input int unsigned n);
    repeat (n) send_item(FN_READ, rand_byte(), rand_bit());
  endtask

  // Reads right after reset: slot zero, then an empty queue
  task automatic test_reset_reads();
    send_item(FN_READ, 8'h00, 1'b0);
    send_item(FN_READ, 8'hFF, 1'b1);
  endtask

  // Idle phase drops bytes without the address bit and foreign addresses
  task automatic test_idle_filter();
    send_item(FN_RX, 8'h00, 1'b0);
    send_item(FN_RX, 8'hFF, 1'b1);
  endtask

  // One frame per delimiter at the reset station address, good and bad sums
  task automatic test_delimiters();
    logic [7:0] csum;
    for (int unsigned k = 0; k < 6; k++) begin
      send_item(FN_RX, 8'h00, 1'b1);
      // address-flagged byte inside a frame is plain data
      if (k == 0) send_item(FN_RX, 8'hFF, 1'b1);
      send_item(FN_RX, delim_byte(k), k[0]);
      csum = frame_sum & mfr_pkg::SUM_MASK;
      if (k == 1) csum = 8'hFF;
      else if (k % 2 == 1) csum = csum | 8'h80;
      send_item(FN_RX, csum, k[1]);
    end
  endtask

  // Drain the first stored bytes
  task automatic test_queue_reads();
    send_reads(2);
  endtask

  // Random frames, noise and read bursts over several station addresses
  task automatic test_random_traffic();
    int unsigned step;
    int unsigned pick;
    step = 0;
    while (sent_cnt < WORK_TARGET) begin
      if (step % 8 == 0) begin
        case (step / 8)
          0:       set_station(8'hFF);
          1:       set_station(8'h00);
          default: set_station(rand_byte());
        endcase
      end
      idle_en = (sent_cnt + QUIET_TAIL < WORK_TARGET);
      pick    = $urandom_range(0, 9);
      if (pick == 0)
        send_noise($urandom_range(1, 6));
      else if (pick == 1)
        send_reads(($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
                                               : $urandom_range(1, 8));
      else if (pick == 2)
        send_frame($urandom_range(64, 90), rand_bit());
      else
        send_frame($urandom_range(0, 8), rand_bit());
      step++;
    end
  endtask

  // Output stalls in random bursts
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      hold_cycles = $urandom_range(1, 15) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("unexpected result: ack_valid=%0b ack_byte=%02h read_data=%02h phase=%0d",
                   ack_valid_o, ack_byte_o, read_data_o, receive_phase_o);
      end else begin
        got_exp = reply_q.pop_front();
        if (ack_valid_o !== got_exp.ack_valid || ack_byte_o !== got_exp.ack_byte ||
            read_data_o !== got_exp.read_data || receive_phase_o !== got_exp.phase) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display({"result %0d mismatch: exp ack_valid=%0b ack_byte=%02h ",
                      "read_data=%02h phase=%0d, got ack_valid=%0b ack_byte=%02h ",
                      "read_data=%02h phase=%0d"},
                     checked_cnt, got_exp.ack_valid, got_exp.ack_byte, got_exp.read_data,
                     got_exp.phase, ack_valid_o, ack_byte_o, read_data_o, receive_phase_o);
        end
        checked_cnt++;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_multidrop_frame_receiver_unit: done, errors");
    $finish;
  end

  // Test sequence
  initial begin
    station_addr = 8'h00;
    rx_phase     = mfr_pkg::PH_ADDR;
    frame_sum    = 8'h00;
    wr_ptr       = '0;
    rd_ptr       = PTR_W'(RING_DEPTH - 1);
    ring_mem     = '{default: 8'h00};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_reads();
    test_idle_filter();
    test_delimiters();
    test_queue_reads();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display({"covered: %0d transfers (%0d not ignored), %0d results checked, ",
              "%0d frames, %0d ack / %0d nak"},
             sent_cnt, work_cnt, checked_cnt, frames_opened, acks_good, acks_bad);
    $display({"covered: %0d reads with data, %0d empty reads, %0d ring overruns, ",
              "%0d address writes"},
             read_hits, empty_reads, ring_overruns, cfg_writes);
    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("tb_multidrop_frame_receiver_unit: done, clean");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", err_cnt, reply_q.size());
      $display("tb_multidrop_frame_receiver_unit: done, errors");
    end
    $finish;
  end

endmodule
